/* rtl/core/telnet_command_parser_core_defines.svh */
// assertion macros for the telnet command parser checker
`ifndef TELNET_COMMAND_PARSER_CORE_DEFINES_SVH
`define TELNET_COMMAND_PARSER_CORE_DEFINES_SVH

// property sampled on clk, off while reset is asserted
`define TCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define TCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tcp_pkg.sv */
`timescale 1ns / 1ps
package tcp_pkg;

	localparam int SUB_BUFFER_LEN = 256;
	localparam int CNT_W = $clog2(SUB_BUFFER_LEN);
	localparam logic [CNT_W-1:0] CLOSE_LIMIT = CNT_W'(SUB_BUFFER_LEN - 4);

	localparam logic [7:0] B_IAC = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB = 8'd250;
	localparam logic [7:0] B_AYT = 8'd246;
	localparam logic [7:0] B_SE = 8'd240;
	localparam logic [7:0] CMD_FIRST = 8'd236;
	localparam logic [7:0] OPT_TM = 8'd6;
	localparam logic [7:0] OPT_TTYPE = 8'd24;
	localparam logic [7:0] OPT_NAWS = 8'd31;
	localparam logic [7:0] TTYPE_SEND = 8'd1;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_Y = 8'h79;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_S = 8'h73;
	localparam logic [7:0] CH_RBRACK = 8'h5d;

	localparam logic [15:0] DEF_WIDTH = 16'd80;
	localparam logic [15:0] DEF_HEIGHT = 16'd23;
	localparam logic [15:0] MIN_WIDTH = 16'd3;
	localparam logic [15:0] MIN_HEIGHT = 16'd2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		RESP_NONE,
		RESP_AYT,
		RESP_TM,
		RESP_TTYPE
	} resp_kind_t;

	// one classified request handed from the front to the back
	typedef struct packed {
		resp_kind_t  kind;
		logic [1:0]  verb;
		logic [15:0] width;
		logic [15:0] height;
	} resp_t;

	function automatic logic [2:0] resp_len(resp_kind_t kind);
		logic [2:0] n;
		unique case (kind)
			RESP_NONE:  n = 3'd1;
			RESP_AYT:   n = 3'd7;
			RESP_TM:    n = 3'd3;
			RESP_TTYPE: n = 3'd6;
		endcase
		return n;
	endfunction

	// verb sent back for a held WILL, WONT, DO, DONT
	function automatic logic [7:0] verb_answer(logic [1:0] verb);
		logic [7:0] r;
		unique case (verb)
			2'd0: r = B_DO;
			2'd1: r = B_DONT;
			2'd2: r = B_WILL;
			2'd3: r = B_WONT;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] resp_byte(resp_kind_t kind, logic [1:0] verb,
			logic [2:0] idx);
		logic [7:0] r;
		unique case (kind)
			RESP_NONE: r = 8'd0;
			RESP_AYT: begin
				unique case (idx)
					3'd1: r = CH_LBRACK;
					3'd2: r = CH_Y;
					3'd3: r = CH_E;
					3'd4: r = CH_S;
					3'd5: r = CH_RBRACK;
					default: r = CH_LF;
				endcase
			end
			RESP_TM: begin
				unique case (idx)
					3'd0: r = B_IAC;
					3'd1: r = verb_answer(verb);
					default: r = OPT_TM;
				endcase
			end
			RESP_TTYPE: begin
				unique case (idx)
					3'd0: r = B_IAC;
					3'd1: r = B_SB;
					3'd2: r = OPT_TTYPE;
					3'd3: r = TTYPE_SEND;
					3'd4: r = B_IAC;
					default: r = B_SE;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/tcp_in_if.sv */
`timescale 1ns / 1ps
interface tcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       chunk_end;

	modport source(output valid, rx_byte, chunk_end, input ready);
	modport sink(input valid, rx_byte, chunk_end, output ready);
endinterface

/* rtl/core/tcp_out_if.sv */
`timescale 1ns / 1ps
interface tcp_out_if;
	logic        valid;
	logic        ready;
	logic        has_byte;
	logic [7:0]  tx_byte;
	logic        last_of_run;
	logic [15:0] window_width;
	logic [15:0] window_height;

	modport source(output valid, has_byte, tx_byte, last_of_run, window_width, window_height,
		input ready);
	modport sink(input valid, has_byte, tx_byte, last_of_run, window_width, window_height,
		output ready);
endinterface

/* rtl/core/tcp_front.sv */
`timescale 1ns / 1ps
module tcp_front (
	input  logic           clk,
	input  logic           arst_n,
	tcp_in_if.sink         rx,
	input  logic           q_full,
	output logic           push,
	output tcp_pkg::resp_t push_data
);
	import tcp_pkg::*;

	typedef enum logic [1:0] {
		MODE_DATA,
		MODE_IAC,
		MODE_VERB,
		MODE_DISCARD
	} mode_t;

	typedef logic [4:0][7:0] sb_buf_t;

	mode_t            mode_q, mode_d;
	logic [1:0]       verb_q, verb_d;
	logic             insub_q, insub_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	sb_buf_t          sbuf_q, sbuf_d;
	logic [15:0]      width_q, width_d;
	logic [15:0]      height_q, height_d;
	resp_kind_t       kind_d;
	logic             close;
	logic [7:0]       b;

	// entry 0 is the option byte, entries 1..4 the first payload bytes
	function automatic sb_buf_t sb_put(sb_buf_t sb_in, logic [CNT_W:0] pos, logic [7:0] val);
		sb_buf_t r;
		r = sb_in;
		for (int i = 0; i < 5; i++) begin
			if (pos == (CNT_W+1)'(i))
				r[i] = val;
		end
		return r;
	endfunction

	assign b = rx.rx_byte;
	assign rx.ready = !q_full;
	assign push = rx.valid && !q_full;

	always_comb begin
		mode_d = mode_q;
		verb_d = verb_q;
		insub_d = insub_q;
		cnt_d = cnt_q;
		sbuf_d = sbuf_q;
		width_d = width_q;
		height_d = height_q;
		kind_d = RESP_NONE;
		close = 1'b0;

		unique case (mode_q)
			MODE_DATA: begin
				if (b == B_IAC) begin
					mode_d = MODE_IAC;
				end else if (insub_q) begin
					sbuf_d = sb_put(sbuf_d, {1'b0, cnt_q}, b);
					cnt_d = cnt_q + 1'b1;
					close = (cnt_d > CLOSE_LIMIT);
				end
			end
			MODE_IAC: begin
				if (b < CMD_FIRST) begin
					mode_d = rx.chunk_end ? MODE_DATA : MODE_DISCARD;
				end else if (b >= B_WILL && b <= B_DONT) begin
					verb_d = 2'(b - B_WILL);
					mode_d = MODE_VERB;
				end else begin
					mode_d = MODE_DATA;
					if (b == B_AYT) begin
						kind_d = RESP_AYT;
					end else if (b == B_SB) begin
						insub_d = 1'b1;
					end else if (b == B_SE) begin
						if (insub_q)
							close = 1'b1;
						else
							cnt_d = '0;
					end
				end
			end
			MODE_VERB: begin
				mode_d = MODE_DATA;
				if (b == OPT_TM) begin
					kind_d = RESP_TM;
				end else if (b == OPT_NAWS) begin
					if (verb_q != 2'd0) begin
						width_d = DEF_WIDTH;
						height_d = DEF_HEIGHT;
					end
				end else if (b == OPT_TTYPE) begin
					if (verb_q == 2'd0)
						kind_d = RESP_TTYPE;
				end
			end
			MODE_DISCARD: begin
				if (rx.chunk_end)
					mode_d = MODE_DATA;
			end
		endcase

		// subnegotiation close: terminator goes in, then NAWS loads the size
		if (close) begin
			sbuf_d = sb_put(sbuf_d, {1'b0, cnt_d}, B_IAC);
			sbuf_d = sb_put(sbuf_d, {1'b0, cnt_d} + 1'b1, B_SE);
			if (sbuf_d[0] == OPT_NAWS) begin
				width_d = {sbuf_d[1], sbuf_d[2]};
				height_d = {sbuf_d[3], sbuf_d[4]};
				if (width_d < MIN_WIDTH)
					width_d = DEF_WIDTH;
				if (height_d < MIN_HEIGHT)
					height_d = DEF_HEIGHT;
			end
			insub_d = 1'b0;
			cnt_d = '0;
		end
	end

	assign push_data = '{kind: kind_d, verb: verb_q, width: width_d, height: height_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DATA;
			verb_q <= '0;
			insub_q <= 1'b0;
			cnt_q <= '0;
			sbuf_q <= '0;
			width_q <= DEF_WIDTH;
			height_q <= DEF_HEIGHT;
		end else if (push) begin
			mode_q <= mode_d;
			verb_q <= verb_d;
			insub_q <= insub_d;
			cnt_q <= cnt_d;
			sbuf_q <= sbuf_d;
			width_q <= width_d;
			height_q <= height_d;
		end
	end

endmodule

/* rtl/core/tcp_fifo.sv */
`timescale 1ns / 1ps
module tcp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcp_pkg::resp_t push_data,
	output logic           full,
	input  logic           pop,
	output tcp_pkg::resp_t pop_data,
	output logic           empty
);
	import tcp_pkg::*;

	resp_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/core/tcp_back.sv */
`timescale 1ns / 1ps
module tcp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  tcp_pkg::resp_t head,
	output logic           pop,
	tcp_out_if.source      tx
);
	import tcp_pkg::*;

	logic [2:0]  idx_q;
	logic        valid_q;
	logic        has_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic        load;
	logic        take;
	logic        is_last;

	// the output register frees whenever the sink takes the current result
	assign load = !valid_q || tx.ready;
	assign take = load && !empty;
	assign is_last = (idx_q == resp_len(head.kind) - 3'd1);
	assign pop = take && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			valid_q <= 1'b1;
		end else if (load) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			has_q <= (head.kind != RESP_NONE);
			byte_q <= resp_byte(head.kind, head.verb, idx_q);
			last_q <= is_last;
			width_q <= head.width;
			height_q <= head.height;
		end
	end

	assign tx.valid = valid_q;
	assign tx.has_byte = has_q;
	assign tx.tx_byte = byte_q;
	assign tx.last_of_run = last_q;
	assign tx.window_width = width_q;
	assign tx.window_height = height_q;

endmodule

/* rtl/core/telnet_command_parser_core.sv */
`timescale 1ns / 1ps
// a byte accepted by the parser is written into the queue, and the emitter registers its result from there
// throughput: one byte per cycle while the queue is not full; a response of n bytes holds the result port for n results
// and the four-entry queue between parser and emitter fills while a response drains
// reset: arst_n clears parse state, queue and output valid; window size returns to 80 x 23
module telnet_command_parser_core (
	input  logic      clk,
	input  logic      arst_n,
	tcp_in_if.sink    rx,
	tcp_out_if.source tx
);
	import tcp_pkg::*;

	logic  q_full;
	logic  q_empty;
	logic  push;
	logic  pop;
	resp_t push_data;
	resp_t head;

	tcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	tcp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (q_empty)
	);

	tcp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.head   (head),
		.pop    (pop),
		.tx     (tx)
	);

endmodule

/* rtl/core/tcp_checker.sv */
`timescale 1ns / 1ps
`include "telnet_command_parser_core_defines.svh"
module tcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        tx_valid,
	input logic        tx_ready,
	input logic        has_byte,
	input logic [7:0]  tx_byte,
	input logic        last_of_run,
	input logic [15:0] window_width,
	input logic [15:0] window_height
);

	`TCP_ASSERT(a_status_is_last, (tx_valid && !has_byte) |-> last_of_run, "status result not last")
	`TCP_ASSERT(a_status_zero, (tx_valid && !has_byte) |-> (tx_byte == 8'd0), "status byte not zero")
	`TCP_ASSERT_NEXT(a_run_continues, tx_valid && tx_ready && !last_of_run, tx_valid && has_byte, "response run broken")
	`TCP_ASSERT_NEXT(a_hold_stalled, tx_valid && !tx_ready, $stable({has_byte, tx_byte, last_of_run, window_width, window_height}), "stalled result changed")

endmodule

bind telnet_command_parser_core tcp_checker u_tcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tx_valid      (tx.valid),
	.tx_ready      (tx.ready),
	.has_byte      (tx.has_byte),
	.tx_byte       (tx.tx_byte),
	.last_of_run   (tx.last_of_run),
	.window_width  (tx.window_width),
	.window_height (tx.window_height)
);

/* dv/telnet_command_parser_core_test.sv */
`timescale 1ns / 1ps
module telnet_command_parser_core_test;
	import tcp_pkg::*;

	localparam int RX_HOLD_CYCLES = 120;
	localparam int DRAIN_CYCLES = 20;

	typedef logic [7:0] octet_q_t[$];

	typedef struct {
		logic        has_byte;
		logic [7:0]  tx_byte;
		logic        last_of_run;
		logic [15:0] window_width;
		logic [15:0] window_height;
	} reply_t;

	class telnet_reply_tracker;
		typedef enum logic [1:0] {
			MODE_DATA,
			MODE_AFTER_IAC,
			MODE_AFTER_VERB,
			MODE_DISCARD
		} mode_t;

		mode_t       mode;
		logic [1:0]  verb_held;
		bit          sub_open;
		int unsigned sub_len;
		logic [7:0]  sub_option;
		logic [7:0]  sub_data[4];
		logic [15:0] cols;
		logic [15:0] rows;
		logic [7:0]  agreed_verb[4];
		logic [7:0]  ayt_text[7];
		reply_t      pending_replies[$];
		int          failures;

		function new();
			mode = MODE_DATA;
			verb_held = '0;
			sub_open = 0;
			sub_len = 0;
			sub_option = '0;
			foreach (sub_data[i]) sub_data[i] = '0;
			cols = DEF_WIDTH;
			rows = DEF_HEIGHT;
			agreed_verb = '{B_DO, B_DONT, B_WILL, B_WONT};
			ayt_text = '{CH_LF, CH_LBRACK, CH_Y, CH_E, CH_S, CH_RBRACK, CH_LF};
			failures = 0;
		endfunction

		// position 0 is the option, 1..4 the captured bytes, the rest is not kept
		function void store_at(int unsigned pos, logic [7:0] b);
			if (pos == 0) begin
				sub_option = b;
			end else if (pos <= 4) begin
				sub_data[pos-1] = b;
			end
		endfunction

		function void close_subneg();
			store_at(sub_len, B_IAC);
			store_at(sub_len + 1, B_SE);
			if (sub_option == OPT_NAWS) begin
				cols = {sub_data[0], sub_data[1]};
				rows = {sub_data[2], sub_data[3]};
				if (cols < MIN_WIDTH) cols = DEF_WIDTH;
				if (rows < MIN_HEIGHT) rows = DEF_HEIGHT;
			end
			sub_open = 0;
			sub_len = 0;
		endfunction

		function void take_rx_byte(logic [7:0] b, logic chunk_last);
			octet_q_t resp;
			reply_t r;
			resp = {};
			case (mode)
				MODE_DATA: begin
					if (b == B_IAC) begin
						mode = MODE_AFTER_IAC;
					end else if (sub_open) begin
						store_at(sub_len, b);
						sub_len++;
						if (sub_len > SUB_BUFFER_LEN - 4) close_subneg();
					end
				end
				MODE_AFTER_IAC: begin
					if (b < CMD_FIRST) begin
						mode = chunk_last ? MODE_DATA : MODE_DISCARD;
					end else if (b >= B_WILL && b <= B_DONT) begin
						verb_held = 2'(b - B_WILL);
						mode = MODE_AFTER_VERB;
					end else begin
						mode = MODE_DATA;
						if (b == B_AYT) begin
							foreach (ayt_text[i]) resp.push_back(ayt_text[i]);
						end else if (b == B_SB) begin
							sub_open = 1;
						end else if (b == B_SE) begin
							if (sub_open) close_subneg();
							sub_open = 0;
							sub_len = 0;
						end
					end
				end
				MODE_AFTER_VERB: begin
					mode = MODE_DATA;
					if (b == OPT_TM) begin
						resp = {B_IAC, agreed_verb[verb_held], OPT_TM};
					end else if (b == OPT_NAWS) begin
						// anything but WILL refuses the window size
						if (verb_held != 2'd0) begin
							cols = DEF_WIDTH;
							rows = DEF_HEIGHT;
						end
					end else if (b == OPT_TTYPE && verb_held == 2'd0) begin
						resp = {B_IAC, B_SB, OPT_TTYPE, TTYPE_SEND, B_IAC, B_SE};
					end
				end
				default: begin
					if (chunk_last) mode = MODE_DATA;
				end
			endcase
			if (resp.size() == 0) begin
				r = '{1'b0, 8'd0, 1'b1, cols, rows};
				pending_replies.push_back(r);
			end else begin
				foreach (resp[i]) begin
					r = '{1'b1, resp[i], (i == resp.size() - 1), cols, rows};
					pending_replies.push_back(r);
				end
			end
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s expected %0d got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void match_tx(reply_t got);
			reply_t want;
			if (pending_replies.size() == 0) begin
				$error("response with none pending: has_byte %0d tx_byte %0d",
					got.has_byte, got.tx_byte);
				failures++;
				return;
			end
			want = pending_replies.pop_front();
			compare_field("has_byte", 16'(want.has_byte), 16'(got.has_byte));
			compare_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
			compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
			compare_field("window_width", want.window_width, got.window_width);
			compare_field("window_height", want.window_height, got.window_height);
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tcp_in_if rx_ch();
	tcp_out_if tx_ch();

	telnet_command_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.tx(tx_ch)
	);

	telnet_reply_tracker tracker;
	reply_t seen_reply;
	int tx_idle_pct = 10;
	int rx_idle_pct = 71;
	bit ready_hold_pending = 0;
	int sent_bytes = 0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#1_000_000;
		$display("telnet_command_parser_core_test: errors");
		$finish;
	end

	// response side: random back-pressure plus one long hold-off on request
	initial begin
		tx_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold_pending) begin
				ready_hold_pending = 0;
				tx_ch.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
			end
			tx_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && tx_ch.valid && tx_ch.ready) begin
			seen_reply = '{tx_ch.has_byte, tx_ch.tx_byte, tx_ch.last_of_run,
				tx_ch.window_width, tx_ch.window_height};
			tracker.match_tx(seen_reply);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic chunk_last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		rx_ch.chunk_end <= chunk_last;
		do @(posedge clk); while (!rx_ch.ready);
		tracker.take_rx_byte(b, chunk_last);
		sent_bytes++;
		@(negedge clk);
	endtask

	// scatter puts random chunk boundaries inside the sequence
	task automatic send_bytes(input octet_q_t seq, input bit end_last, input bit scatter);
		logic e;
		foreach (seq[i]) begin
			if (i == seq.size() - 1)
				e = end_last;
			else
				e = scatter && ($urandom_range(0, 7) == 0);
			send_byte(seq[i], e);
		end
	endtask

	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		do @(negedge clk); while (tracker.pending() != 0);
	endtask

	task automatic run_directed();
		send_bytes({8'h00, 8'h7f, 8'h80, 8'hfe}, 1'b1, 1'b0);
		send_bytes({B_IAC, B_AYT}, 1'b1, 1'b0);
		for (int v = 0; v < 4; v++)
			send_bytes({B_IAC, 8'(B_WILL + v), OPT_TM}, 1'b1, 1'b0);
		send_bytes({B_IAC, B_DO, OPT_TTYPE}, 1'b1, 1'b0);
		send_bytes({B_IAC, B_WILL, OPT_TTYPE}, 1'b1, 1'b0);
		send_bytes({B_IAC, B_SB, OPT_NAWS, 8'h01, 8'h00, 8'h00, 8'h30, B_IAC, B_SE},
			1'b1, 1'b0);
		// below the minimum size falls back to 80 x 23
		send_bytes({B_IAC, B_SB, OPT_NAWS, 8'h00, 8'h02, 8'h00, 8'h01, B_IAC, B_SE},
			1'b1, 1'b0);
		send_bytes({B_IAC, B_SB, OPT_NAWS, 8'h00, 8'h03, 8'h00, 8'h02, B_IAC, B_SE},
			1'b1, 1'b0);
		send_bytes({B_IAC, B_WILL, OPT_NAWS}, 1'b1, 1'b0);
		send_bytes({B_IAC, B_WONT, OPT_NAWS}, 1'b1, 1'b0);
		send_bytes({B_IAC, B_SB, OPT_NAWS, 8'hfe, 8'hfe, 8'h00, 8'h84, B_IAC, B_SE},
			1'b1, 1'b0);
		send_bytes({B_IAC, B_DO, OPT_NAWS}, 1'b1, 1'b0);
		// invalid command discards the rest of the chunk
		send_bytes({B_IAC, 8'h00, B_IAC, B_AYT}, 1'b1, 1'b0);
		send_bytes({B_IAC, 8'(CMD_FIRST - 1)}, 1'b1, 1'b0);
		send_bytes({B_IAC, B_AYT, B_IAC, CMD_FIRST}, 1'b1, 1'b0);
		// sequences split across chunks
		send_byte(B_IAC, 1'b1);
		send_byte(B_AYT, 1'b1);
		send_byte(B_IAC, 1'b1);
		send_byte(B_DONT, 1'b1);
		send_byte(OPT_TM, 1'b1);
		send_bytes({B_IAC, B_SE}, 1'b1, 1'b0);
		// nested SB and IAC IAC are ignored, short capture keeps terminators
		send_bytes({B_IAC, B_SB, OPT_NAWS, B_IAC, B_SB, 8'h00, B_IAC, B_IAC, 8'h07,
			B_IAC, B_SE}, 1'b1, 1'b0);
		send_bytes({B_IAC, B_SB, B_IAC, B_SE}, 1'b1, 1'b0);
		send_bytes({B_IAC, B_DONT, OPT_NAWS}, 1'b1, 1'b0);
	endtask

	// capture long enough to hit the buffer limit and close on its own
	task automatic run_overflow();
		octet_q_t seq;
		seq = {B_IAC, B_SB, OPT_NAWS, 8'h00, 8'h64, 8'h00, 8'h32};
		repeat (248) seq.push_back(8'($urandom_range(0, 254)));
		seq.push_back(8'h41);
		seq.push_back(B_IAC);
		seq.push_back(B_SE);
		send_bytes(seq, 1'b1, 1'b0);
	endtask

	task automatic send_random_seq();
		octet_q_t seq;
		int pick;
		int len;
		logic [7:0] opt;
		bit end_last;
		pick = $urandom_range(0, 99);
		end_last = ($urandom_range(0, 3) == 0);
		seq = {};
		if (pick < 15) begin
			len = $urandom_range(1, 3);
			repeat (len) seq.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 25) begin
			seq = {B_IAC, B_AYT};
		end else if (pick < 50) begin
			case ($urandom_range(0, 3))
				0: opt = OPT_TM;
				1: opt = OPT_TTYPE;
				2: opt = OPT_NAWS;
				default: opt = 8'($urandom_range(0, 255));
			endcase
			seq = {B_IAC, 8'(B_WILL + $urandom_range(0, 3)), opt};
		end else if (pick < 72) begin
			opt = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 254)) : OPT_NAWS;
			seq = {B_IAC, B_SB, opt};
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4;
			repeat (len) begin
				if ($urandom_range(0, 2) == 0)
					seq.push_back(8'($urandom_range(0, 3)));
				else
					seq.push_back(8'($urandom_range(0, 254)));
			end
			seq.push_back(B_IAC);
			seq.push_back(B_SE);
		end else if (pick < 82) begin
			seq = {B_IAC, 8'($urandom_range(0, CMD_FIRST - 1))};
			len = $urandom_range(0, 3);
			repeat (len) seq.push_back(8'($urandom_range(0, 255)));
			end_last = 1'b1;
		end else if (pick < 92) begin
			seq = {B_IAC, 8'($urandom_range(CMD_FIRST, B_IAC))};
		end else begin
			// capture left open, later traffic lands in it
			seq = {B_IAC, B_SB, OPT_NAWS};
			len = $urandom_range(0, 3);
			repeat (len) seq.push_back(8'($urandom_range(0, 254)));
		end
		send_bytes(seq, end_last, 1'b1);
	endtask

	task automatic random_phase(input int count);
		int stop_at;
		stop_at = sent_bytes + count;
		while (sent_bytes < stop_at) send_random_seq();
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'd0;
		rx_ch.chunk_end = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		run_directed();
		random_phase(34);
		wait_drained();

		tx_idle_pct = 71;
		rx_idle_pct = 10;
		random_phase(33);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		ready_hold_pending = 1;
		run_overflow();
		random_phase(33);

		rx_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.failures == 0)
			$display("telnet_command_parser_core_test: clean");
		else
			$display("telnet_command_parser_core_test: errors");
		$finish;
	end
endmodule
